>>> rtl/core/sha256_pkg.sv
// Package for the SHA-256 digest block: constants, round constants, helpers.
// No dependencies.
`default_nettype none
package sha256_pkg;
  localparam int QueueDepthDef = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_ADD, ST_OUT
  } sha_state_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
    return k[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/sha256_ifc.sv
// Valid/ready channel interfaces for the digest block.
// Depends on nothing.
`default_nettype none
interface sha256_in_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;
  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha256_out_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sha256_queue.sv
// Front part: accepts input transactions, drops empty ones, queues the rest.
// Depends on sha256_pkg.
`default_nettype none
module sha256_queue
  import sha256_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sha_item_t in_item,
  output logic           q_valid,
  input  wire logic      q_ready,
  output sha_item_t      q_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_item_t        mem_r [Depth];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             push, pop;

  assign in_ready = (cnt_r != (AW+1)'(Depth));
  // items with neither byte nor last change nothing and are dropped here
  assign push = in_valid && in_ready && (in_item.has_byte || in_item.last);
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule
`default_nettype wire

>>> rtl/core/sha256_core.sv
// Back part: byte packing, padding, 64-round compression, digest output.
// Depends on sha256_pkg.
`default_nettype none
module sha256_core
  import sha256_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  output logic           q_ready,
  input  wire sha_item_t q_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [31:0]    out_digest_word,
  output logic [2:0]     out_word_index,
  output logic           out_last_word
);
  sha_state_t    st_r, st_nxt;
  logic [31:0]   w_r [16];
  logic [31:0]   h_r [8];
  logic [31:0]   v_r [8];
  logic [60:0]   cnt_r;
  logic [5:0]    fill_r;
  logic [6:0]    rnd_r;
  logic [2:0]    lenidx_r;
  logic          fin_r;     // the taken item was last: the message is being finished
  logic [2:0]    oidx_r;
  logic          pad_done_r; // all length bytes placed
  logic          pad_put_r;  // 0x80 byte placed
  logic          len_blk_r;  // length field goes in the current block

  // byte to put this cycle
  logic          put;
  logic [7:0]    pbyte;
  logic [63:0]   bits;
  logic          take;

  assign bits = {cnt_r, 3'b000};
  assign take = (st_r == ST_IDLE) && q_valid;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        if (q_item.has_byte && fill_r == 6'd63) st_nxt = ST_ROUND;
        else if (q_item.last) st_nxt = ST_PAD;
      end
      ST_PAD: st_nxt = (fill_r == 6'd63) ? ST_ROUND : ST_LEN;
      ST_LEN: begin
        if (fill_r == 6'd63) st_nxt = ST_ROUND;
        else if (fill_r < LenOffset) st_nxt = ST_LEN;
      end
      ST_ROUND: if (rnd_r == 7'd63) st_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) st_nxt = ST_IDLE;
        else if (lenidx_r == 3'd0 && fill_r == 6'd0 && pad_done_r) st_nxt = ST_OUT;
        else if (!pad_put_r) st_nxt = ST_PAD;
        else st_nxt = ST_LEN;
      end
      ST_OUT: if (out_ready && oidx_r == 3'd7) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs / byte selection
  always_comb begin
    put = 1'b0;
    pbyte = 8'h00;
    q_ready = (st_r == ST_IDLE);
    case (st_r)
      ST_IDLE: begin
        put = q_valid && q_item.has_byte;
        pbyte = q_item.data_byte;
      end
      ST_PAD: begin
        put = 1'b1;
        pbyte = PadByte;
      end
      ST_LEN: begin
        put = 1'b1;
        pbyte = (fill_r >= LenOffset && len_blk_r) ? bits[(7 - lenidx_r) * 8 +: 8]
                                                   : 8'h00;
      end
      default: ;
    endcase
  end

  assign out_valid = (st_r == ST_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

  // round datapath with on-the-fly message schedule in w_r
  logic [31:0] s0, s1, wn, wt, t1, t2, e, a;
  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    wt = w_r[0];
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + round_k(rnd_r[5:0]) + wt;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      fill_r <= '0;
      rnd_r <= '0;
      lenidx_r <= '0;
      fin_r <= 1'b0;
      pad_done_r <= 1'b0;
      pad_put_r <= 1'b0;
      len_blk_r <= 1'b0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[(7 - i) * 32 +: 32];
    end else begin
      st_r <= st_nxt;
      if (take) begin
        fin_r <= q_item.last;
        pad_done_r <= 1'b0;
        pad_put_r <= 1'b0;
        lenidx_r <= '0;
        if (q_item.has_byte) cnt_r <= cnt_r + 61'd1;
      end
      // length fits after the pad byte only if the pad lands before byte 56
      if (st_r == ST_PAD) begin
        pad_put_r <= 1'b1;
        len_blk_r <= (fill_r < LenOffset);
      end
      if (st_r == ST_ADD) len_blk_r <= 1'b1;
      if (put) begin
        fill_r <= fill_r + 6'd1;
        if (st_r == ST_LEN && fill_r >= LenOffset && len_blk_r) begin
          lenidx_r <= lenidx_r + 3'd1;
          if (lenidx_r == 3'd7) pad_done_r <= 1'b1;
        end
        if (fill_r == 6'd63)
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      if (st_r == ST_ROUND) begin
        rnd_r <= (rnd_r == 7'd63) ? 7'd0 : rnd_r + 7'd1;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (st_r == ST_ADD)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (st_r == ST_OUT && out_ready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          cnt_r <= '0;
          fill_r <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= InitHash[(7 - i) * 32 +: 32];
        end
      end
    end
    // message words: pack bytes, then shift as a schedule window
    if (put)
      w_r[fill_r[5:2]][(3 - fill_r[1:0]) * 8 +: 8] <= pbyte;
    if (st_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wn;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sha256_message_digest.sv
// Top level of the SHA-256 digest block: input queue and hashing core.
// Depends on sha256_pkg, sha256_ifc, sha256_queue, sha256_core.
//
//  channel | dir | fields
//  in_     | in  | data_byte[7:0], has_byte, last
//  out_    | out | digest_word[31:0], word_index[2:0], last_word
//
// Each byte is packed into the message block; a full block then runs the rounds
// and the add step in the shared round unit. A last transaction adds padding bytes,
// one or two compressions and the eight digest words on the output.
// Reset is synchronous; the queue keeps taking transactions while the core
// works or the output stalls, until it holds QueueDepth items.
`default_nettype none
module sha256_message_digest
  import sha256_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input wire logic clk,
  input wire logic rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  sha_item_t in_item, q_item;
  logic      q_valid, q_ready;

  assign in_item = '{data_byte: in_ch.data_byte, has_byte: in_ch.has_byte,
                     last: in_ch.last};

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  sha256_core u_core (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_item,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_digest_word(out_ch.digest_word), .out_word_index(out_ch.word_index),
    .out_last_word(out_ch.last_word)
  );
endmodule
`default_nettype wire
